FILE: sv/hpa_pkg.sv
// Package for the HSLA pixel adjuster: types, constants and arithmetic helpers.
`default_nettype none

package hpa_pkg;

    // Fixed-point scales.
    localparam logic [16:0] FULL_SCALE  = 17'd65536;
    localparam logic [16:0] AMOUNT_RST  = 17'd6554;
    localparam logic signed [18:0] HUE_FULL_S = 19'sd46080;
    localparam logic signed [17:0] HUE_FULL_D = 18'sd46080;
    localparam logic signed [17:0] HUE_HALF_D = 18'sd23040;
    localparam logic [15:0] HUE_ORANGE  = 16'd1408;
    localparam logic [15:0] HUE_BLUE    = 16'd27648;

    // Configuration register indexes.
    localparam logic [1:0] CFG_MODE      = 2'd0;
    localparam logic [1:0] CFG_AMOUNT    = 2'd1;
    localparam logic [1:0] CFG_HUE_SHIFT = 2'd2;

    typedef enum logic [2:0] {
        MODE_LIGHTEN    = 3'd0,
        MODE_DARKEN     = 3'd1,
        MODE_SATURATE   = 3'd2,
        MODE_DESATURATE = 3'd3,
        MODE_GRAYSCALE  = 3'd4,
        MODE_ROTATE     = 3'd5,
        MODE_SNAP       = 3'd6
    } t_mode;

    typedef struct packed {
        logic [15:0] hue;
        logic [16:0] sat;
        logic [16:0] lum;
        logic [16:0] alpha;
    } t_pixel;

    typedef struct packed {
        t_mode              mode;
        logic [16:0]        amount;
        logic signed [16:0] hue_shift;
    } t_cfg;

    // Add and clamp at full scale.
    function automatic logic [16:0] sat_add(input logic [16:0] v, input logic [16:0] a);
        logic [17:0] s;
        s = {1'b0, v} + {1'b0, a};
        return (s > {1'b0, FULL_SCALE}) ? FULL_SCALE : s[16:0];
    endfunction

    // Subtract and clamp at zero; an over-range result is held at full scale.
    function automatic logic [16:0] sat_sub(input logic [16:0] v, input logic [16:0] a);
        logic [16:0] d;
        d = v - a;
        if (v < a) begin
            d = 17'd0;
        end else if (d > FULL_SCALE) begin
            d = FULL_SCALE;
        end
        return d;
    endfunction

    // Signed hue rotation with a single wrap, then clamp to the circle.
    function automatic logic [15:0] hue_rotate(input logic [15:0] h,
                                               input logic signed [16:0] sh);
        logic signed [18:0] s;
        s = $signed({3'b000, h}) + $signed({{2{sh[16]}}, sh});
        if (s > HUE_FULL_S) begin
            s = s - HUE_FULL_S;
        end else if (s < 19'sd0) begin
            s = s + HUE_FULL_S;
        end
        if (s > HUE_FULL_S) begin
            s = HUE_FULL_S;
        end else if (s < 19'sd0) begin
            s = 19'sd0;
        end
        return s[15:0];
    endfunction

    // Circular distance in whole degrees, truncated toward zero. It can go
    // negative when the hue lies above the full circle.
    function automatic logic signed [10:0] circ_dist(input logic [15:0] h,
                                                     input logic [15:0] t);
        logic signed [17:0] d;
        logic [17:0]        mag;
        logic [10:0]        q;
        d = $signed({2'b00, h}) - $signed({2'b00, t});
        if (d < 18'sd0) begin
            d = -d;
        end
        if (d > HUE_HALF_D) begin
            d = HUE_FULL_D - d;
        end
        mag = d[17] ? 18'(-d) : 18'(d);
        q   = mag[17:7];
        return d[17] ? -$signed(q) : $signed(q);
    endfunction

    // Snap to the nearer of the two target hues; a tie goes to orange.
    function automatic logic [15:0] hue_snap(input logic [15:0] h);
        logic signed [10:0] dor;
        logic signed [10:0] dbl;
        dor = circ_dist(h, HUE_ORANGE);
        dbl = circ_dist(h, HUE_BLUE);
        return (dbl < dor) ? HUE_BLUE : HUE_ORANGE;
    endfunction

endpackage

`default_nettype wire

FILE: sv/hpa_cfg.sv
// Configuration register file for the HSLA pixel adjuster.
`default_nettype none

module hpa_cfg
    import hpa_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [1:0]  i_cfg_index,
    input  wire logic [16:0] i_cfg_data,
    output t_cfg             o_cfg
);

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.mode      <= MODE_LIGHTEN;
            r_cfg.amount    <= AMOUNT_RST;
            r_cfg.hue_shift <= 17'sd0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_MODE:      r_cfg.mode      <= t_mode'(i_cfg_data[2:0]);
                CFG_AMOUNT:    r_cfg.amount    <= i_cfg_data;
                CFG_HUE_SHIFT: r_cfg.hue_shift <= $signed(i_cfg_data);
                default:       r_cfg           <= r_cfg;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

FILE: sv/hpa_core.sv
// Per-pixel adjust logic: applies the selected operation to one HSLA pixel.
`default_nettype none

module hpa_core
    import hpa_pkg::*;
(
    input  t_cfg   i_cfg,
    input  t_pixel i_pix,
    output t_pixel o_pix
);

    always_comb begin
        o_pix = i_pix;
        case (i_cfg.mode)
            MODE_LIGHTEN:    o_pix.lum = sat_add(i_pix.lum, i_cfg.amount);
            MODE_DARKEN:     o_pix.lum = sat_sub(i_pix.lum, i_cfg.amount);
            MODE_SATURATE:   o_pix.sat = sat_add(i_pix.sat, i_cfg.amount);
            MODE_DESATURATE: o_pix.sat = sat_sub(i_pix.sat, i_cfg.amount);
            MODE_GRAYSCALE:  o_pix.sat = 17'd0;
            MODE_ROTATE:     o_pix.hue = hue_rotate(i_pix.hue, i_cfg.hue_shift);
            MODE_SNAP:       o_pix.hue = hue_snap(i_pix.hue);
            default:         o_pix     = i_pix;
        endcase
    end

endmodule

`default_nettype wire

FILE: sv/hsl_pixel_adjust.sv
// Top level of the HSLA pixel adjuster: input register, adjust logic, result register.
//
//  Channel   Handshake            Payload
//  input     i_valid / o_ready    i_hue_in, i_sat_in, i_lum_in, i_alpha_in
//  output    o_valid / i_ready    o_hue_out, o_sat_out, o_lum_out, o_alpha_out
//  config    i_cfg_we (no wait)   i_cfg_index, i_cfg_data
//
// A pixel accepted at an edge sits in the input register and moves into the
// result register, where it is presented, when that register is free or being
// drained. The input register and the result register each hold one
// transaction, and one pixel is accepted every clock while the output side
// keeps up. The only logic between the two registers is the mode's adjust logic.
// Reset (i_rst_n low, synchronous) empties both registers and loads the
// configuration defaults. When the output stalls, the result register holds
// and the input register can still take one more transaction.
`default_nettype none

module hsl_pixel_adjust
    import hpa_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [1:0]  i_cfg_index,
    input  wire logic [16:0] i_cfg_data,
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire logic [15:0] i_hue_in,
    input  wire logic [16:0] i_sat_in,
    input  wire logic [16:0] i_lum_in,
    input  wire logic [16:0] i_alpha_in,
    output logic             o_valid,
    input  wire logic        i_ready,
    output logic [15:0]      o_hue_out,
    output logic [16:0]      o_sat_out,
    output logic [16:0]      o_lum_out,
    output logic [16:0]      o_alpha_out
);

    t_cfg   w_cfg;
    t_pixel r_s1_pix;
    t_pixel n_s1_pix;
    t_pixel w_adj_pix;
    t_pixel r_out_pix;
    logic   r_s1_valid;
    logic   r_out_valid;
    logic   w_s1_adv;
    logic   w_in_acc;

    hpa_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (w_cfg)
    );

    // The input register moves on whenever the result register is free or
    // being drained this cycle; it takes a new transaction when it is empty
    // or moving on.
    assign w_s1_adv = !r_out_valid || i_ready;
    assign o_ready  = !r_s1_valid || w_s1_adv;
    assign w_in_acc = i_valid && o_ready;

    assign n_s1_pix = '{hue: i_hue_in, sat: i_sat_in, lum: i_lum_in, alpha: i_alpha_in};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (o_ready) begin
            r_s1_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_s1_pix <= n_s1_pix;
        end
    end

    hpa_core u_core (
        .i_cfg (w_cfg),
        .i_pix (r_s1_pix),
        .o_pix (w_adj_pix)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_s1_adv) begin
            r_out_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_s1_adv && r_s1_valid) begin
            r_out_pix <= w_adj_pix;
        end
    end

    assign o_valid     = r_out_valid;
    assign o_hue_out   = r_out_pix.hue;
    assign o_sat_out   = r_out_pix.sat;
    assign o_lum_out   = r_out_pix.lum;
    assign o_alpha_out = r_out_pix.alpha;

    // An accepted transaction always lands in the input register.
    a_in_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_acc |=> r_s1_valid)
        else $error("accepted transaction did not reach the input register");

    // A pixel that leaves the input register becomes a presented result.
    a_s1_to_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && w_s1_adv) |=> o_valid)
        else $error("pixel lost between input and result registers");

    // A pixel held in the input register during a stall is not dropped.
    a_s1_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && !w_s1_adv) |=> (r_s1_valid && $stable(r_s1_pix)))
        else $error("stalled pixel dropped or changed in the input register");

    // Reset empties both registers.
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> (!r_s1_valid && !o_valid))
        else $error("registers not empty after reset");

endmodule

`default_nettype wire
